@@ hw/rtl/sgnfb_pkg.sv @@
// ----------------------------------------------------------------------------
// Sequence gap receiver package
// Shared constants, codes and controller/datapath types.
// ----------------------------------------------------------------------------
package sgnfb_pkg;

    localparam int FRAME_SLOTS = 256;
    localparam int SLOT_AW     = $clog2(FRAME_SLOTS);
    localparam int CNT_W       = SLOT_AW + 1;
    localparam int REQ_DEPTH   = 64;
    localparam int REQ_AW      = $clog2(REQ_DEPTH);
    localparam int REQ_CW      = REQ_AW + 1;
    localparam int DIV_STEPS   = 32;
    localparam int DIV_CW      = $clog2(DIV_STEPS);

    localparam logic [15:0] PPF_RESET = 16'd2831;
    localparam logic [7:0]  FPP_RESET = 8'd25;

    // Configuration register indexes.
    typedef enum logic {
        CFG_PPF = 1'b0,
        CFG_FPP = 1'b1
    } t_cfg_idx;

    // Item kinds.
    typedef enum logic [1:0] {
        MODE_ARRIVE = 2'd0,
        MODE_PLAY   = 2'd1,
        MODE_RETX   = 2'd2,
        MODE_NONE   = 2'd3
    } t_mode;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_SETUP,
        ST_DIV,
        ST_GAP,
        ST_FRAME,
        ST_LATE_RD,
        ST_LATE_WR,
        ST_PLAY,
        ST_POP,
        ST_DONE
    } t_state;

    // Controller to datapath commands.
    typedef struct packed {
        logic load_item;
        logic setup;
        logic div_step;
        logic gap_step;
        logic frame_upd;
        logic late_rd;
        logic late_wr;
        logic play_step;
        logic play_end;
        logic pop;
        logic res_load;
    } t_cmd;

    // Datapath to controller status.
    typedef struct packed {
        t_mode mode;
        logic  is_late;
        logic  div_done;
        logic  gap_done;
        logic  play_ok;
        logic  play_done;
        logic  req_nonempty;
    } t_status;

endpackage

@@ hw/rtl/sgnfb_if.sv @@
// ----------------------------------------------------------------------------
// Sequence gap receiver channels
// Input item and result item channels with valid/ready handshake.
// ----------------------------------------------------------------------------
interface sgnfb_in_if;
    logic        valid;
    logic        ready;
    logic [1:0]  mode;
    logic [31:0] seq_num;
    logic [15:0] pkt_bytes;

    modport source (output valid, mode, seq_num, pkt_bytes, input ready);
    modport sink   (input valid, mode, seq_num, pkt_bytes, output ready);
endinterface

interface sgnfb_out_if;
    logic        valid;
    logic        ready;
    logic        req_valid;
    logic [31:0] req_seq;
    logic        played;
    logic [8:0]  frames_buffered;
    logic        queue_overflow;

    modport source (output valid, req_valid, req_seq, played, frames_buffered,
                    queue_overflow, input ready);
    modport sink   (input valid, req_valid, req_seq, played, frames_buffered,
                    queue_overflow, output ready);
endinterface

@@ hw/rtl/seq_gap_nack_frame_buffer_unit.sv @@
// Arrivals queue at most 64 missing numbers per item.
// The divider is bit-serial (32 steps) and playout clears one slot per cycle.
// Throughput: one item at a time; the next item is taken while a result waits.
// Reset (synchronous, active low) empties the queue, slots and counters at once.
// ----------------------------------------------------------------------------
// Sequence gap receiver top level
// Retransmission request queue and frame buffer with playout.
// ----------------------------------------------------------------------------
module seq_gap_nack_frame_buffer_unit import sgnfb_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    sgnfb_in_if.sink    in_if,
    sgnfb_out_if.source out_if,
    input  logic        i_cfg_we,
    input  logic        i_cfg_idx,
    input  logic [15:0] i_cfg_data
);

    t_cmd    cmd;
    t_status status;

    // Controller.
    sgnfb_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (in_if.valid),
        .o_in_ready  (in_if.ready),
        .o_out_valid (out_if.valid),
        .i_out_ready (out_if.ready),
        .i_status    (status),
        .o_cmd       (cmd)
    );

    // Datapath.
    sgnfb_datapath u_dp (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cfg_we          (i_cfg_we),
        .i_cfg_idx         (i_cfg_idx),
        .i_cfg_data        (i_cfg_data),
        .i_mode            (in_if.mode),
        .i_seq_num         (in_if.seq_num),
        .i_pkt_bytes       (in_if.pkt_bytes),
        .i_cmd             (cmd),
        .o_status          (status),
        .o_req_valid       (out_if.req_valid),
        .o_req_seq         (out_if.req_seq),
        .o_played          (out_if.played),
        .o_frames_buffered (out_if.frames_buffered),
        .o_queue_overflow  (out_if.queue_overflow)
    );

endmodule

@@ hw/rtl/sgnfb_ctrl.sv @@
// ----------------------------------------------------------------------------
// Sequence gap receiver controller
// Sequences one item at a time through the datapath and owns the handshakes.
// ----------------------------------------------------------------------------
module sgnfb_ctrl import sgnfb_pkg::*; (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_in_valid,
    output logic    o_in_ready,
    output logic    o_out_valid,
    input  logic    i_out_ready,
    input  t_status i_status,
    output t_cmd    o_cmd
);

    t_state r_state, n_state;
    logic   r_out_valid, n_out_valid;
    logic   out_free;

    assign out_free    = !r_out_valid || i_out_ready;
    assign o_out_valid = r_out_valid;

    // State and output-valid registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    // Next state and commands.
    always_comb begin
        n_state     = r_state;
        n_out_valid = r_out_valid && !i_out_ready;
        o_cmd       = '0;
        o_in_ready  = 1'b0;
        case (r_state)
            ST_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.load_item = 1'b1;
                    n_state         = ST_SETUP;
                end
            end
            ST_SETUP: begin
                o_cmd.setup = 1'b1;
                case (i_status.mode)
                    MODE_ARRIVE: n_state = ST_DIV;
                    MODE_PLAY:   n_state = i_status.play_ok ? ST_PLAY : ST_DONE;
                    MODE_RETX:   n_state = i_status.req_nonempty ? ST_POP : ST_DONE;
                    default:     n_state = ST_DONE;
                endcase
            end
            ST_DIV: begin
                o_cmd.div_step = 1'b1;
                if (i_status.div_done) begin
                    n_state = i_status.is_late ? ST_LATE_RD : ST_GAP;
                end
            end
            ST_GAP: begin
                if (i_status.gap_done) begin
                    n_state = ST_FRAME;
                end else begin
                    o_cmd.gap_step = 1'b1;
                end
            end
            ST_FRAME: begin
                o_cmd.frame_upd = 1'b1;
                n_state         = ST_DONE;
            end
            ST_LATE_RD: begin
                o_cmd.late_rd = 1'b1;
                n_state       = ST_LATE_WR;
            end
            ST_LATE_WR: begin
                o_cmd.late_wr = 1'b1;
                n_state       = ST_DONE;
            end
            ST_PLAY: begin
                if (i_status.play_done) begin
                    o_cmd.play_end = 1'b1;
                    n_state        = ST_DONE;
                end else begin
                    o_cmd.play_step = 1'b1;
                end
            end
            ST_POP: begin
                o_cmd.pop = 1'b1;
                n_state   = ST_DONE;
            end
            ST_DONE: begin
                if (out_free) begin
                    o_cmd.res_load = 1'b1;
                    n_out_valid    = 1'b1;
                    n_state        = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

endmodule

@@ hw/rtl/sgnfb_datapath.sv @@
// ----------------------------------------------------------------------------
// Sequence gap receiver datapath
// Divider, request queue, frame slot store, counters and result register.
// ----------------------------------------------------------------------------
module sgnfb_datapath import sgnfb_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic        i_cfg_idx,
    input  logic [15:0] i_cfg_data,
    input  logic [1:0]  i_mode,
    input  logic [31:0] i_seq_num,
    input  logic [15:0] i_pkt_bytes,
    input  t_cmd        i_cmd,
    output t_status     o_status,
    output logic        o_req_valid,
    output logic [31:0] o_req_seq,
    output logic        o_played,
    output logic [8:0]  o_frames_buffered,
    output logic        o_queue_overflow
);

    // Configuration.
    logic [15:0] r_ppf;
    logic [7:0]  r_fpp;
    logic [7:0]  fpp_eff;

    // Item registers.
    t_mode       r_mode;
    logic [31:0] r_seq;
    logic [15:0] r_bytes;

    // Receiver state.
    logic [31:0]       r_expected;
    logic [31:0]       r_open_frame;
    logic              r_have_open;
    logic [31:0]       r_open_bytes;
    logic [SLOT_AW-1:0] r_play_front;
    logic [CNT_W-1:0]  r_completed;
    logic [REQ_AW-1:0] r_req_head;
    logic [REQ_CW-1:0] r_req_count;

    // Stores.
    logic [31:0]        frame_mem [FRAME_SLOTS];
    logic [FRAME_SLOTS-1:0] r_slot_vld;
    logic [31:0]        req_mem [REQ_DEPTH];
    logic [31:0]        r_slot_rd;
    logic               r_slot_rd_vld;

    // Divider.
    logic [15:0]       r_div_d;
    logic [31:0]       r_quot;
    logic [16:0]       r_rem;
    logic [DIV_CW-1:0] r_div_cnt;
    logic [16:0]       div_trial;
    logic              div_ge;

    // Gap and playout loops.
    logic [REQ_CW-1:0] r_gap_left;
    logic [31:0]       r_gap_val;
    logic [7:0]        r_play_left;
    logic [31:0]       gap;
    logic [REQ_CW-1:0] room;
    logic              gap_fits;

    // Per-item results and output register.
    logic        r_res_req_valid;
    logic [31:0] r_res_req_seq;
    logic        r_res_played;
    logic        r_res_ovf;
    logic        r_out_req_valid;
    logic [31:0] r_out_req_seq;
    logic        r_out_played;
    logic [8:0]  r_out_frames;
    logic        r_out_ovf;

    logic [REQ_AW-1:0]  req_tail;
    logic [SLOT_AW-1:0] late_slot;
    logic [32:0]        open_sum;
    logic [32:0]        late_sum;
    logic [32:0]        open_sum_pkt;

    assign fpp_eff   = (r_fpp == '0) ? 8'd1 : r_fpp;
    assign gap       = r_seq - r_expected;
    assign room      = REQ_CW'(REQ_DEPTH) - r_req_count;
    assign gap_fits  = gap <= {{(32-REQ_CW){1'b0}}, room};
    assign req_tail  = r_req_head + r_req_count[REQ_AW-1:0];
    assign late_slot = r_quot[SLOT_AW-1:0];
    assign div_trial = {r_rem[15:0], r_quot[31]};
    assign div_ge    = div_trial >= {1'b0, r_div_d};
    assign open_sum  = {1'b0, r_open_bytes} + {17'd0, r_bytes};
    assign late_sum  = {1'b0, r_slot_rd} + {17'd0, r_bytes};
    assign open_sum_pkt = open_sum;

    // Status to the controller.
    always_comb begin
        o_status.mode         = r_mode;
        o_status.is_late      = r_seq < r_expected;
        o_status.div_done     = r_div_cnt == '0;
        o_status.gap_done     = r_gap_left == '0;
        o_status.play_ok      = {1'b0, fpp_eff} <= r_completed;
        o_status.play_done    = r_play_left == '0;
        o_status.req_nonempty = r_req_count != '0;
    end

    // Configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ppf <= PPF_RESET;
            r_fpp <= FPP_RESET;
        end else if (i_cfg_we) begin
            case (t_cfg_idx'(i_cfg_idx))
                CFG_PPF: r_ppf <= i_cfg_data;
                CFG_FPP: r_fpp <= i_cfg_data[7:0];
                default: ;
            endcase
        end
    end

    // Item capture, divider, gap loop and playout counters.
    always_ff @(posedge i_clk) begin
        if (i_cmd.load_item) begin
            r_mode  <= t_mode'(i_mode);
            r_seq   <= i_seq_num;
            r_bytes <= i_pkt_bytes;
        end
        if (i_cmd.setup) begin
            r_div_d     <= (r_ppf == '0) ? 16'd1 : r_ppf;
            r_quot      <= r_seq;
            r_rem       <= '0;
            r_div_cnt   <= DIV_CW'(DIV_STEPS - 1);
            r_gap_val   <= r_expected;
            r_gap_left  <= gap_fits ? gap[REQ_CW-1:0] : room;
            r_play_left <= fpp_eff;
        end
        // One quotient bit per cycle.
        if (i_cmd.div_step) begin
            r_rem     <= div_ge ? (div_trial - {1'b0, r_div_d}) : div_trial;
            r_quot    <= {r_quot[30:0], div_ge};
            r_div_cnt <= r_div_cnt - 1'b1;
        end
        if (i_cmd.gap_step) begin
            r_gap_val  <= r_gap_val + 32'd1;
            r_gap_left <= r_gap_left - 1'b1;
        end
        if (i_cmd.play_step) begin
            r_play_left <= r_play_left - 8'd1;
        end
    end

    // Per-item result flags.
    always_ff @(posedge i_clk) begin
        if (i_cmd.load_item) begin
            r_res_req_valid <= 1'b0;
            r_res_req_seq   <= '0;
            r_res_played    <= 1'b0;
            r_res_ovf       <= 1'b0;
        end
        if (i_cmd.setup) begin
            r_res_ovf    <= (r_mode == MODE_ARRIVE) && !o_status.is_late && !gap_fits;
            r_res_played <= (r_mode == MODE_PLAY) && o_status.play_ok;
        end
        if (i_cmd.pop) begin
            r_res_req_valid <= 1'b1;
            r_res_req_seq   <= req_mem[r_req_head];
        end
    end

    // Receiver control state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_expected   <= '0;
            r_open_frame <= '0;
            r_have_open  <= 1'b0;
            r_open_bytes <= '0;
            r_play_front <= '0;
            r_completed  <= '0;
            r_req_head   <= '0;
            r_req_count  <= '0;
            r_slot_vld   <= '0;
        end else begin
            if (i_cmd.gap_step) begin
                r_req_count <= r_req_count + 1'b1;
            end
            if (i_cmd.pop) begin
                r_req_head  <= r_req_head + 1'b1;
                r_req_count <= r_req_count - 1'b1;
            end
            // Close or extend the open frame.
            if (i_cmd.frame_upd) begin
                r_expected <= r_seq + 32'd1;
                if (r_have_open && r_quot == r_open_frame) begin
                    r_open_bytes <= open_sum_pkt[32] ? '1 : open_sum_pkt[31:0];
                end else begin
                    if (r_have_open) begin
                        r_slot_vld[r_open_frame[SLOT_AW-1:0]] <= 1'b1;
                        if (r_completed != CNT_W'(FRAME_SLOTS)) begin
                            r_completed <= r_completed + 1'b1;
                        end
                    end
                    r_open_frame <= r_quot;
                    r_have_open  <= 1'b1;
                    r_open_bytes <= {16'd0, r_bytes};
                end
            end
            // Clear one slot per cycle during playout.
            if (i_cmd.play_step) begin
                r_slot_vld[r_play_front] <= 1'b0;
                r_play_front             <= r_play_front + 1'b1;
            end
            if (i_cmd.play_end) begin
                r_completed <= r_completed - {1'b0, fpp_eff};
            end
        end
    end

    // Frame slot store.
    always_ff @(posedge i_clk) begin
        if (i_cmd.frame_upd && r_have_open && r_quot != r_open_frame) begin
            frame_mem[r_open_frame[SLOT_AW-1:0]] <= r_open_bytes;
        end else if (i_cmd.late_wr && r_slot_rd_vld && r_slot_rd != '0) begin
            frame_mem[late_slot] <= late_sum[32] ? '1 : late_sum[31:0];
        end
        if (i_cmd.late_rd) begin
            r_slot_rd     <= frame_mem[late_slot];
            r_slot_rd_vld <= r_slot_vld[late_slot];
        end
    end

    // Request queue store.
    always_ff @(posedge i_clk) begin
        if (i_cmd.gap_step) begin
            req_mem[req_tail] <= r_gap_val;
        end
    end

    // Output register.
    always_ff @(posedge i_clk) begin
        if (i_cmd.res_load) begin
            r_out_req_valid <= r_res_req_valid;
            r_out_req_seq   <= r_res_req_seq;
            r_out_played    <= r_res_played;
            r_out_frames    <= r_completed;
            r_out_ovf       <= r_res_ovf;
        end
    end

    assign o_req_valid       = r_out_req_valid;
    assign o_req_seq         = r_out_req_seq;
    assign o_played          = r_out_played;
    assign o_frames_buffered = r_out_frames;
    assign o_queue_overflow  = r_out_ovf;

endmodule
